@@ rtl/nnss_pkg.sv @@
// Shared types and constants for the nearest-neighbor sprite scaler.
`default_nettype none
package nnss_pkg;

    // Field widths fixed by the interface.
    localparam int DIM_W   = 7;
    localparam int COLOR_W = 16;
    localparam int NUM_W   = 2 * DIM_W;
    localparam int DIV_W   = NUM_W - 1;

    // Largest legal image or destination dimension, and the register reset value.
    localparam logic [DIM_W-1:0] MAX_DIM   = 7'd96;
    localparam logic [DIM_W-1:0] DIM_RESET = 7'd96;

    // Number of division cells: one quotient bit per cell.
    localparam int NUM_CELLS = DIM_W;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_DEST_SIZE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_HEIGHT = 2'd2;

    // Input item.
    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic [DIM_W-1:0]   src_col;
        logic [DIM_W-1:0]   src_row;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [COLOR_W-1:0] fill_color;
        logic [DIM_W-1:0]   dest_x;
        logic [DIM_W-1:0]   span_width;
        logic [DIM_W-1:0]   dest_y;
        logic [DIM_W-1:0]   span_height;
    } out_item_t;

    // Work in flight along the cell chain: four divisions run side by side.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [NUM_W-1:0]   rem_y0;
        logic [NUM_W-1:0]   rem_y1;
        logic [NUM_W-1:0]   rem_x0;
        logic [NUM_W-1:0]   rem_x1;
        logic [DIM_W-1:0]   quo_y0;
        logic [DIM_W-1:0]   quo_y1;
        logic [DIM_W-1:0]   quo_x0;
        logic [DIM_W-1:0]   quo_x1;
        logic [DIV_W-1:0]   div_h;
        logic [DIV_W-1:0]   div_w;
    } token_t;

endpackage
`default_nettype wire

@@ rtl/nnss_front.sv @@
// Input stage: range checks, products and numerator setup for the divider chain.
`default_nettype none
module nnss_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [nnss_pkg::DIM_W-1:0] dest_size,
    input  wire logic [nnss_pkg::DIM_W-1:0] src_width,
    input  wire logic [nnss_pkg::DIM_W-1:0] src_height,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire nnss_pkg::in_item_t         s_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output nnss_pkg::token_t                out_tok
);
    import nnss_pkg::*;

    logic               valid_reg, valid_next;
    logic [COLOR_W-1:0] color_reg;
    logic [NUM_W-1:0]   prod_row_reg;
    logic [NUM_W-1:0]   prod_col_reg;
    logic               item_ok;

    // An item is usable only with legal registers and an in-range coordinate.
    always_comb begin
        item_ok = (dest_size != '0) && (dest_size <= MAX_DIM) &&
                  (src_width != '0) && (src_width <= MAX_DIM) &&
                  (src_height != '0) && (src_height <= MAX_DIM) &&
                  (s_data.src_col < src_width) && (s_data.src_row < src_height);
    end

    assign s_ready = !valid_reg || out_ready;

    // Occupancy: rejected items are taken but never enter the chain.
    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid && item_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Products of coordinate and destination size.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            color_reg    <= s_data.pixel_color;
            prod_row_reg <= {{DIM_W{1'b0}}, s_data.src_row} * {{DIM_W{1'b0}}, dest_size};
            prod_col_reg <= {{DIM_W{1'b0}}, s_data.src_col} * {{DIM_W{1'b0}}, dest_size};
        end
    end

    // Numerators for the four divisions; columns round up, rows round down.
    always_comb begin
        out_tok        = '0;
        out_tok.color  = color_reg;
        out_tok.rem_y0 = prod_row_reg;
        out_tok.rem_y1 = prod_row_reg + {{DIM_W{1'b0}}, dest_size};
        out_tok.rem_x0 = prod_col_reg + {{DIM_W{1'b0}}, src_width} - NUM_W'(1);
        out_tok.rem_x1 = prod_col_reg + {{DIM_W{1'b0}}, dest_size}
                         + {{DIM_W{1'b0}}, src_width} - NUM_W'(1);
        out_tok.div_h  = {src_height, {(DIV_W-DIM_W){1'b0}}};
        out_tok.div_w  = {src_width, {(DIV_W-DIM_W){1'b0}}};
    end

    assign out_valid = valid_reg;

endmodule
`default_nettype wire

@@ rtl/nnss_cell.sv @@
// One restoring-division cell: resolves one quotient bit of all four divisions.
`default_nettype none
module nnss_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire nnss_pkg::token_t in_tok,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output nnss_pkg::token_t      out_tok
);
    import nnss_pkg::*;

    logic   valid_reg, valid_next;
    token_t tok_reg, tok_next;
    logic   ge_y0, ge_y1, ge_x0, ge_x1;

    assign in_ready = !valid_reg || out_ready;

    // Compare each remainder against its divisor at this cell's bit weight.
    always_comb begin
        ge_y0 = in_tok.rem_y0 >= {1'b0, in_tok.div_h};
        ge_y1 = in_tok.rem_y1 >= {1'b0, in_tok.div_h};
        ge_x0 = in_tok.rem_x0 >= {1'b0, in_tok.div_w};
        ge_x1 = in_tok.rem_x1 >= {1'b0, in_tok.div_w};
    end

    // Subtract where it fits, shift in the quotient bit, halve the divisors.
    always_comb begin
        tok_next        = in_tok;
        tok_next.rem_y0 = ge_y0 ? in_tok.rem_y0 - {1'b0, in_tok.div_h} : in_tok.rem_y0;
        tok_next.rem_y1 = ge_y1 ? in_tok.rem_y1 - {1'b0, in_tok.div_h} : in_tok.rem_y1;
        tok_next.rem_x0 = ge_x0 ? in_tok.rem_x0 - {1'b0, in_tok.div_w} : in_tok.rem_x0;
        tok_next.rem_x1 = ge_x1 ? in_tok.rem_x1 - {1'b0, in_tok.div_w} : in_tok.rem_x1;
        tok_next.quo_y0 = {in_tok.quo_y0[DIM_W-2:0], ge_y0};
        tok_next.quo_y1 = {in_tok.quo_y1[DIM_W-2:0], ge_y1};
        tok_next.quo_x0 = {in_tok.quo_x0[DIM_W-2:0], ge_x0};
        tok_next.quo_x1 = {in_tok.quo_x1[DIM_W-2:0], ge_x1};
        tok_next.div_h  = in_tok.div_h >> 1;
        tok_next.div_w  = in_tok.div_w >> 1;
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            tok_reg <= tok_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule
`default_nettype wire

@@ rtl/nnss_back.sv @@
// Output stage: span widths, empty-span drop and the result register.
`default_nettype none
module nnss_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire nnss_pkg::token_t  in_tok,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output nnss_pkg::out_item_t    m_data
);
    import nnss_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t data_reg, data_next;
    logic      span_ok;

    assign in_ready = !valid_reg || m_ready;

    // A pixel skipped by downscaling has an empty row or column span.
    always_comb begin
        span_ok = (in_tok.quo_y1 > in_tok.quo_y0) && (in_tok.quo_x1 > in_tok.quo_x0);
        data_next.fill_color  = in_tok.color;
        data_next.dest_x      = in_tok.quo_x0;
        data_next.span_width  = in_tok.quo_x1 - in_tok.quo_x0;
        data_next.dest_y      = in_tok.quo_y0;
        data_next.span_height = in_tok.quo_y1 - in_tok.quo_y0;
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = span_ok;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule
`default_nettype wire

@@ rtl/nearest_neighbor_sprite_scaler_core.sv @@
// Top level of the nearest-neighbor sprite scaler: registers and the cell chain.
//
// Usage: each input item on s_valid/s_ready/s_data is one RGB565 source pixel
// with its column and row. For each pixel the block returns at most one item on
// m_valid/m_ready/m_data: the destination rectangle that pixel paints in a
// square destination of dest_size pixels, with the same color. Pixels with an
// out-of-range coordinate, illegal registers, or an empty span are dropped.
// Registers are to be written through cfg_wr_en/cfg_addr/cfg_wr_data only while idle;
// the block does not enforce this. Throughput is one item per cycle while m_ready
// does not stall the chain. The product register loads at the accepting edge,
// then one cell per quotient bit (7 cells) and the output register, which drives m_valid. Every
// stage holds an item and its own valid bit, so bubbles close up and input
// stays open while a result waits; a stall on m_ready backs up the chain only
// once every stage is full.
// Reset clears every valid bit and sets all three registers to 96.
`default_nettype none
module nearest_neighbor_sprite_scaler_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [nnss_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [nnss_pkg::DIM_W-1:0]      cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire nnss_pkg::in_item_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output nnss_pkg::out_item_t                  m_data
);
    import nnss_pkg::*;

    logic [DIM_W-1:0] dest_size_reg, dest_size_next;
    logic [DIM_W-1:0] src_width_reg, src_width_next;
    logic [DIM_W-1:0] src_height_reg, src_height_next;

    logic   chain_valid [NUM_CELLS+1];
    logic   chain_ready [NUM_CELLS+1];
    token_t chain_tok   [NUM_CELLS+1];

    // Register writes; unknown indexes are ignored.
    always_comb begin
        dest_size_next  = dest_size_reg;
        src_width_next  = src_width_reg;
        src_height_next = src_height_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DEST_SIZE:  dest_size_next  = cfg_wr_data;
                REG_SRC_WIDTH:  src_width_next  = cfg_wr_data;
                REG_SRC_HEIGHT: src_height_next = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_size_reg  <= DIM_RESET;
            src_width_reg  <= DIM_RESET;
            src_height_reg <= DIM_RESET;
        end else begin
            dest_size_reg  <= dest_size_next;
            src_width_reg  <= src_width_next;
            src_height_reg <= src_height_next;
        end
    end

    // Products and numerators.
    nnss_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dest_size  (dest_size_reg),
        .src_width  (src_width_reg),
        .src_height (src_height_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .out_valid  (chain_valid[0]),
        .out_ready  (chain_ready[0]),
        .out_tok    (chain_tok[0])
    );

    // Division chain, most significant quotient bit first.
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        nnss_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_tok    (chain_tok[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_tok   (chain_tok[i+1])
        );
    end

    // Spans and result register.
    nnss_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (chain_valid[NUM_CELLS]),
        .in_ready (chain_ready[NUM_CELLS]),
        .in_tok   (chain_tok[NUM_CELLS]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

@@ bench/nnss_rect_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts each painted destination rectangle and compares it with the result channel.
module nnss_rect_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [nnss_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [nnss_pkg::DIM_W-1:0]      cfg_wr_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  nnss_pkg::in_item_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  nnss_pkg::out_item_t             m_data,
    output int                              rects_pending,
    output int                              fail_count
);
    import nnss_pkg::*;

    // Shadow copies of the scaler registers.
    logic [DIM_W-1:0] dest_size;
    logic [DIM_W-1:0] src_width;
    logic [DIM_W-1:0] src_height;

    // Rectangles still owed by the block, oldest first.
    out_item_t expected_rects[$];
    int        bad_rects = 0;

    // Work out the rectangle one source pixel paints; returns 0 when it paints nothing.
    function automatic bit paint_rect(input in_item_t px, input logic [DIM_W-1:0] s,
                                      input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                      output out_item_t rect);
        int unsigned si, wi, hi, col, row, cap;
        int unsigned y0, y1, x0, x1;
        si   = 32'(s);
        wi   = 32'(w);
        hi   = 32'(h);
        col  = 32'(px.src_col);
        row  = 32'(px.src_row);
        cap  = 32'(MAX_DIM);
        rect = '0;
        // Any illegal register disables the block.
        if (si == 0 || si > cap || wi == 0 || wi > cap || hi == 0 || hi > cap)
            return 1'b0;
        // Pixels outside the source image are dropped.
        if (col >= wi || row >= hi)
            return 1'b0;
        // Rows round down at both ends.
        y0 = (row * si) / hi;
        y1 = ((row + 1) * si) / hi;
        if (y1 <= y0)
            return 1'b0;
        // Columns round up at both ends.
        x0 = (col * si + wi - 1) / wi;
        x1 = ((col + 1) * si + wi - 1) / wi;
        if (x1 <= x0)
            return 1'b0;
        rect.fill_color  = px.pixel_color;
        rect.dest_x      = DIM_W'(x0);
        rect.span_width  = DIM_W'(x1 - x0);
        rect.dest_y      = DIM_W'(y0);
        rect.span_height = DIM_W'(y1 - y0);
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        out_item_t rect;
        if (!aresetn) begin
            dest_size  = DIM_RESET;
            src_width  = DIM_RESET;
            src_height = DIM_RESET;
            expected_rects.delete();
        end else begin
            // Register writes; the spare index is ignored.
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_DEST_SIZE:  dest_size  = cfg_wr_data;
                    REG_SRC_WIDTH:  src_width  = cfg_wr_data;
                    REG_SRC_HEIGHT: src_height = cfg_wr_data;
                    default: ;
                endcase
            end

            // Compare each delivered rectangle with the oldest one owed.
            if (m_valid && m_ready) begin
                if (expected_rects.size() == 0) begin
                    bad_rects++;
                    if (bad_rects <= 10)
                        $display("unexpected rect: color %h x %0d w %0d y %0d h %0d",
                                 m_data.fill_color, m_data.dest_x, m_data.span_width,
                                 m_data.dest_y, m_data.span_height);
                end else begin
                    want = expected_rects.pop_front();
                    if (want.fill_color  !== m_data.fill_color  ||
                        want.dest_x      !== m_data.dest_x      ||
                        want.span_width  !== m_data.span_width  ||
                        want.dest_y      !== m_data.dest_y      ||
                        want.span_height !== m_data.span_height) begin
                        bad_rects++;
                        if (bad_rects <= 10) begin
                            $write("rect mismatch: expected color %h x %0d w %0d y %0d h %0d,",
                                   want.fill_color, want.dest_x, want.span_width,
                                   want.dest_y, want.span_height);
                            $display(" got color %h x %0d w %0d y %0d h %0d",
                                     m_data.fill_color, m_data.dest_x, m_data.span_width,
                                     m_data.dest_y, m_data.span_height);
                        end
                    end
                end
            end

            // Each accepted pixel owes at most one rectangle.
            if (s_valid && s_ready &&
                paint_rect(s_data, dest_size, src_width, src_height, rect))
                expected_rects.push_back(rect);
        end
        rects_pending <= expected_rects.size();
        fail_count    <= bad_rects;
    end

endmodule

@@ bench/nearest_neighbor_sprite_scaler_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the sprite scaler testbench: clock, reset, pixel and register stimulus, and the verdict.
module nearest_neighbor_sprite_scaler_core_tb;
    import nnss_pkg::*;

    localparam int PHASES        = 12;
    localparam int PHASE_PIXELS  = 62;
    localparam int PIPE_LATENCY  = 9;
    localparam int DRAIN_CYCLES  = PIPE_LATENCY + 4;
    localparam int STALL_LIMIT   = 2000;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [DIM_W-1:0]      cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    in_item_t              s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    out_item_t             m_data;

    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int idle_cycles    = 0;
    int rects_pending;
    int fail_count;

    // Source image size currently programmed, used to aim random pixels.
    int cur_w = 96;
    int cur_h = 96;

    initial begin
        forever #4 aclk = ~aclk;
    end

    nearest_neighbor_sprite_scaler_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    nnss_rect_checker rect_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .rects_pending (rects_pending),
        .fail_count    (fail_count)
    );

    // Result side back-pressure.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Register write; the caller lowers the enable after the last one.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] s, input logic [DIM_W-1:0] w,
                            input logic [DIM_W-1:0] h);
        write_reg(REG_DEST_SIZE, s);
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, h);
        cfg_wr_en <= 1'b0;
        cur_w = int'(w);
        cur_h = int'(h);
    endtask

    // Offer one pixel, with an optional random gap first; returns at the next falling edge.
    task automatic send_pixel(input in_item_t px);
        if ($urandom_range(0, 99) < src_gap_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < src_gap_pct);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Hold off the sender until every owed rectangle has arrived.
    task automatic drain_all();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (rects_pending != 0) @(negedge aclk);
    endtask

    // Let dropped pixels clear the pipeline too before touching registers.
    task automatic settle();
        drain_all();
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        in_item_t         px;
        logic [DIM_W-1:0] s, w, h;

        // Hold reset, then release it.
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Write to the spare register index must not disturb anything.
        write_reg(REG_UNUSED, 7'd0);
        cfg_wr_en <= 1'b0;

        // Reset geometry: corners, color extremes and coordinates off the image.
        send_pixel({16'h0000, 7'd0, 7'd0});
        send_pixel({16'hFFFF, 7'd95, 7'd95});
        send_pixel({16'hA5A5, 7'd95, 7'd0});
        send_pixel({16'h5A5A, 7'd0, 7'd95});
        send_pixel({16'h1234, 7'd96, 7'd0});
        send_pixel({16'h4321, 7'd0, 7'd96});
        send_pixel({16'hFFFF, 7'd127, 7'd127});

        // Downscale: some pixels fall between destination samples.
        settle();
        set_dims(7'd10, 7'd96, 7'd96);
        send_pixel({16'h0F0F, 7'd0, 7'd0});
        send_pixel({16'hF0F0, 7'd1, 7'd1});
        send_pixel({16'h3C3C, 7'd9, 7'd9});
        send_pixel({16'hC3C3, 7'd95, 7'd95});

        // Smallest destination.
        settle();
        set_dims(7'd1, 7'd96, 7'd96);
        send_pixel({16'h8001, 7'd0, 7'd0});
        send_pixel({16'h7FFE, 7'd50, 7'd50});

        // Single source pixel stretched over the whole destination.
        settle();
        set_dims(7'd96, 7'd1, 7'd1);
        send_pixel({16'hBEEF, 7'd0, 7'd0});
        send_pixel({16'hCAFE, 7'd1, 7'd0});

        // Uneven upscale ratios.
        settle();
        set_dims(7'd96, 7'd7, 7'd13);
        send_pixel({16'h1111, 7'd6, 7'd12});
        send_pixel({16'h2222, 7'd3, 7'd5});

        // Illegal register values block every pixel.
        settle();
        set_dims(7'd0, 7'd96, 7'd96);
        send_pixel({16'h3333, 7'd0, 7'd0});
        settle();
        set_dims(7'd97, 7'd96, 7'd96);
        send_pixel({16'h4444, 7'd0, 7'd0});
        settle();
        set_dims(7'd96, 7'd127, 7'd96);
        send_pixel({16'h5555, 7'd0, 7'd0});
        settle();
        set_dims(7'd96, 7'd96, 7'd0);
        send_pixel({16'h6666, 7'd0, 7'd0});

        // Random phases, each with its own geometry and idling pattern.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            case ((p + p / 4) % 4)
                0: begin
                    s = 7'd96;
                    w = DIM_W'($urandom_range(1, 96));
                    h = DIM_W'($urandom_range(1, 96));
                end
                1: begin
                    s = DIM_W'($urandom_range(48, 96));
                    w = 7'd96;
                    h = 7'd96;
                end
                2: begin
                    s = DIM_W'($urandom_range(1, 96));
                    w = DIM_W'($urandom_range(1, int'(s)));
                    h = DIM_W'($urandom_range(1, int'(s)));
                end
                default: begin
                    s = DIM_W'($urandom_range(1, 96));
                    w = DIM_W'($urandom_range(1, 96));
                    h = DIM_W'($urandom_range(1, 96));
                end
            endcase
            if (p == PHASES - 1) begin
                s = 7'd1;
                w = 7'd1;
                h = 7'd1;
            end
            set_dims(s, w, h);

            case (p % 4)
                0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_gap_pct = 83; sink_stall_pct = 0;  end
                2: begin src_gap_pct = 0;  sink_stall_pct = 83; end
                default: begin src_gap_pct = 29; sink_stall_pct = 29; end
            endcase

            for (int n = 0; n < PHASE_PIXELS; n++) begin
                // Once per sender-idle phase, stop until the block has caught up.
                if (p % 4 == 1 && n == PHASE_PIXELS / 2)
                    drain_all();
                px.pixel_color = COLOR_W'($urandom_range(0, 16'hFFFF));
                // Mostly pixels on the image, some anywhere the fields reach.
                if ($urandom_range(0, 9) == 0) begin
                    px.src_col = DIM_W'($urandom_range(0, 127));
                    px.src_row = DIM_W'($urandom_range(0, 127));
                end else begin
                    px.src_col = DIM_W'($urandom_range(0, cur_w - 1));
                    px.src_row = DIM_W'($urandom_range(0, cur_h - 1));
                end
                send_pixel(px);
            end
        end

        // Wait for the last rectangles, then give the verdict.
        drain_all();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && rects_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
